>>> hw/rtl/gcf_pkg.sv
// ----------------------------------------------------------------------------
// gcf_pkg
// Shared types and codes for the graph component finder.
// ----------------------------------------------------------------------------
package gcf_pkg;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_WAIT,
        ST_EMIT
    } gcf_state_t;

endpackage

>>> hw/rtl/gcf_ram.sv
// ----------------------------------------------------------------------------
// gcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/gcf_lowbit.sv
// ----------------------------------------------------------------------------
// gcf_lowbit
// Index of the lowest set bit of a mask (zero when the mask is empty).
// ----------------------------------------------------------------------------
module gcf_lowbit #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0]         mask,
    output logic [$clog2(WIDTH)-1:0] index
);

    always_comb
    begin
        index = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                index = ($clog2(WIDTH))'(i);
            end
        end
    end

endmodule

>>> hw/rtl/graph_component_finder_core.sv
// ----------------------------------------------------------------------------
// graph_component_finder_core
// Directed adjacency table with connected-component search over a subset.
// ----------------------------------------------------------------------------
// A write item stores one adjacency row. A query item walks the subset: each
// vertex of the subset is expanded once, with one adjacency RAM read (ST_READ)
// and one merge of the returned row (ST_WAIT); each component is seeded in
// ST_START and handed to the output register in ST_EMIT, which holds while a
// result waits there untaken. Vertices are expanded one at a time, through
// the single read port of the adjacency RAM. Queries are taken one at a time;
// writes are taken whenever the block is idle, also while a result waits at
// the output.
module graph_component_finder_core #(
    parameter int VERTICES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [5:0]  vertex,
    input  logic [63:0] row_bits,
    input  logic [63:0] subset_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] component_mask,
    output logic        last
);

    import gcf_pkg::*;

    localparam int AW = $clog2(VERTICES);

    gcf_state_t          state_reg, state_next;
    logic [VERTICES-1:0] subset_reg, subset_next;
    logic [VERTICES-1:0] seen_reg, seen_next;
    logic [VERTICES-1:0] comp_reg, comp_next;
    logic [VERTICES-1:0] work_reg, work_next;
    logic [VERTICES-1:0] row_valid_reg;
    logic                rd_valid_reg;
    logic                out_valid_reg;
    logic [VERTICES-1:0] mask_reg;
    logic                last_reg;

    logic [VERTICES-1:0] pending;
    logic [VERTICES-1:0] row_word;
    logic [VERTICES-1:0] new_bits;
    logic [VERTICES-1:0] one_w;
    logic [AW-1:0]       pend_idx;
    logic [AW-1:0]       work_idx;
    logic                in_accept;
    logic                out_load;
    logic                out_last;
    logic                wr_ok;
    logic                ram_we;
    logic                ram_re;
    logic [VERTICES-1:0] ram_rdata;

    assign one_w     = {{(VERTICES-1){1'b0}}, 1'b1};
    assign pending   = subset_reg & ~seen_reg;
    assign row_word  = rd_valid_reg ? ram_rdata : '0;
    assign new_bits  = row_word & subset_reg & ~seen_reg;
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign out_last  = (pending == '0);
    assign wr_ok     = ({1'b0, vertex} < 7'(VERTICES));
    assign ram_we    = in_accept && (action == ACT_WRITE) && wr_ok;
    assign ram_re    = (state_reg == ST_READ) && (work_reg != '0);

    gcf_lowbit #(.WIDTH(VERTICES)) u_pend_low (
        .mask  (pending),
        .index (pend_idx)
    );

    gcf_lowbit #(.WIDTH(VERTICES)) u_work_low (
        .mask  (work_reg),
        .index (work_idx)
    );

    gcf_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_adj_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vertex[AW-1:0]),
        .wdata (row_bits[VERTICES-1:0]),
        .re    (ram_re),
        .raddr (work_idx),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (action == ACT_QUERY))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = (pending == '0) ? ST_IDLE : ST_READ;
            end
            ST_READ:
            begin
                state_next = (work_reg == '0) ? ST_EMIT : ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_READ;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = out_last ? ST_IDLE : ST_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        subset_next = subset_reg;
        seen_next   = seen_reg;
        comp_next   = comp_reg;
        work_next   = work_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (action == ACT_QUERY))
                begin
                    subset_next = subset_mask[VERTICES-1:0];
                    seen_next   = '0;
                end
            end
            ST_START:
            begin
                seen_next = seen_reg | (one_w << pend_idx);
                comp_next = one_w << pend_idx;
                work_next = one_w << pend_idx;
            end
            ST_READ:
            begin
                work_next = work_reg & ~(one_w << work_idx);
            end
            ST_WAIT:
            begin
                seen_next = seen_reg | new_bits;
                comp_next = comp_reg | new_bits;
                work_next = work_reg | new_bits;
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                row_valid_reg[vertex[AW-1:0]] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_valid_reg <= row_valid_reg[work_idx];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        subset_reg <= subset_next;
        seen_reg   <= seen_next;
        comp_reg   <= comp_next;
        work_reg   <= work_next;
        if (out_load)
        begin
            mask_reg <= comp_reg;
            last_reg <= out_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign component_mask = 64'(mask_reg);
    assign last           = last_reg;

    a_comp_in_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_WAIT) |->
            ((comp_reg & ~subset_reg) == '0) && ((comp_reg & ~seen_reg) == '0))
        else $error("component holds vertices outside subset or unseen");

    a_work_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_WAIT) |->
            ((work_reg & ~comp_reg) == '0))
        else $error("work list holds vertices outside the component");

    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mask_reg != '0))
        else $error("empty component offered");

    a_last_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last) |=> (state_reg == ST_IDLE) && last_reg)
        else $error("final component did not end the query");

endmodule

>>> test/component_checker.sv
// ----------------------------------------------------------------------------
// component_checker
// Watches both channels of the component finder, keeps its own copy of the
// adjacency table, works out the components of every query and compares
// each result item against the oldest expected component.
// ----------------------------------------------------------------------------
module component_checker #(
    parameter int VERTICES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [5:0]  vertex,
    input  logic [63:0] row_bits,
    input  logic [63:0] subset_mask,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] component_mask,
    input  logic        last,
    output int          mismatches,
    output int          pending,
    output int          checked
);

    import gcf_pkg::*;

    localparam logic [63:0] LIVE_VERTICES =
        (VERTICES >= 64) ? '1 : ((64'd1 << VERTICES) - 64'd1);
    localparam int FIFO_DEPTH = 256;

    typedef struct packed {
        logic [63:0] members;
        logic        last;
    } component_t;

    logic [63:0] graph_rows [64];
    component_t  expected_fifo [FIFO_DEPTH];
    int          head_count;
    int          tail_count;
    component_t  oldest;
    logic        bad;

    // Breadth-first walk from each unseen subset vertex, lowest index first.
    task automatic find_components(input logic [63:0] subset);
        logic [63:0] members_in;
        logic [63:0] seen;
        logic [63:0] unvisited;
        logic [63:0] found;
        logic [63:0] frontier;
        logic [63:0] reach;
        logic [63:0] fresh;
        int          root;
        members_in = subset & LIVE_VERTICES;
        seen = '0;
        unvisited = members_in;
        while (unvisited != '0)
        begin
            root = 0;
            while (!unvisited[root])
                root++;
            seen[root] = 1'b1;
            found = '0;
            found[root] = 1'b1;
            frontier = found;
            while (frontier != '0)
            begin
                reach = '0;
                for (int v = 0; v < 64; v++)
                    if (frontier[v])
                        reach |= graph_rows[v];
                fresh = reach & members_in & ~seen;
                seen |= fresh;
                found |= fresh;
                frontier = fresh;
            end
            unvisited = members_in & ~seen;
            expected_fifo[tail_count % FIFO_DEPTH] =
                '{members: found, last: (unvisited == '0)};
            tail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < 64; v++)
                graph_rows[v] = '0;
            head_count = 0;
            tail_count = 0;
            mismatches <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tail_count == head_count)
                begin
                    $display("%0t: unexpected component: expected none, got mask %h last %b",
                             $time, component_mask, last);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    oldest = expected_fifo[head_count % FIFO_DEPTH];
                    head_count++;
                    bad = 1'b0;
                    if (component_mask !== oldest.members)
                    begin
                        $display("%0t: component_mask mismatch: expected %h, got %h",
                                 $time, oldest.members, component_mask);
                        bad = 1'b1;
                    end
                    if (last !== oldest.last)
                    begin
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $time, oldest.last, last);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches <= mismatches + 1;
                    checked <= checked + 1;
                end
            end
            if (in_valid && in_ready)
            begin
                if (action == ACT_WRITE)
                begin
                    if (vertex < VERTICES)
                        graph_rows[vertex] = row_bits & LIVE_VERTICES;
                end
                else
                    find_components(subset_mask);
            end
            pending <= tail_count - head_count;
        end
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for graph_component_finder_core.
// Directed row writes and queries cover empty and full subsets, self edges,
// one-way edges and chains; then a random mix of writes and queries runs in
// bursts against a stalling receiver while component_checker scores results.
// ----------------------------------------------------------------------------
module testbench;
    import gcf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        action = ACT_WRITE;
    logic [5:0]  vertex = '0;
    logic [63:0] row_bits = '0;
    logic [63:0] subset_mask = '0;
    logic        out_ready = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [63:0] component_mask;
    wire         last;

    int mismatches;
    int pending;
    int checked;
    int writes_sent = 0;
    int queries_sent = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int rx_cycle = 0;

    always #10 clk = ~clk;

    graph_component_finder_core #(
        .VERTICES(64)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .vertex(vertex),
        .row_bits(row_bits),
        .subset_mask(subset_mask),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .component_mask(component_mask),
        .last(last)
    );

    component_checker #(
        .VERTICES(64)
    ) CHECK (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .vertex(vertex),
        .row_bits(row_bits),
        .subset_mask(subset_mask),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .component_mask(component_mask),
        .last(last),
        .mismatches(mismatches),
        .pending(pending),
        .checked(checked)
    );

    // Receiver: switches between free-running, random, mostly stalled and
    // periodic ready patterns.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        rx_cycle++;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((rx_cycle % 5) < 2);
        endcase
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] few_bits(input int count);
        logic [63:0] bits;
        bits = '0;
        for (int i = 0; i < count; i++)
            bits[$urandom_range(0, 63)] = 1'b1;
        return bits;
    endfunction

    task automatic send_item(input logic act, input logic [5:0] vtx,
                             input logic [63:0] row, input logic [63:0] sub);
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        vertex <= vtx;
        row_bits <= row;
        subset_mask <= sub;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act == ACT_WRITE)
            writes_sent++;
        else
            queries_sent++;
    endtask

    // Unused fields carry random values; the block must ignore them.
    task automatic write_row(input logic [5:0] vtx, input logic [63:0] row);
        send_item(ACT_WRITE, vtx, row, rand64());
    endtask

    task automatic query(input logic [63:0] sub);
        send_item(ACT_QUERY, 6'($urandom_range(0, 63)), rand64(), sub);
    endtask

    task automatic gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic random_item();
        logic [5:0]  v;
        logic [63:0] bits;
        int          lo;
        int          hi;
        v = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 40)
        begin
            case ($urandom_range(0, 5))
                0: bits = rand64();
                1: bits = '0;
                2: bits = 64'd1 << 6'(v + 6'd1);
                3: bits = '1;
                default: bits = few_bits($urandom_range(1, 3))
                                | (64'd1 << 6'(v + 6'($urandom_range(1, 3))));
            endcase
            write_row(v, bits);
        end
        else
        begin
            case ($urandom_range(0, 6))
                0: bits = '1;
                1: bits = rand64();
                2: bits = few_bits($urandom_range(1, 8));
                3: bits = rand64() & rand64();
                4: bits = '0;
                default:
                begin
                    lo = $urandom_range(0, 63);
                    hi = $urandom_range(lo, 63);
                    bits = '0;
                    for (int i = lo; i <= hi; i++)
                        bits[i] = 1'b1;
                end
            endcase
            query(bits);
        end
    endtask

    initial
    begin
        int sent;
        int burst;
        bit paused;
        sent = 0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        query('0);
        query('1);
        write_row(6'd0, '1);
        write_row(6'd63, '0);
        query('1);
        query(64'h8000_0000_0000_0000);
        write_row(6'd0, '0);
        write_row(6'd5, 64'd1 << 5);
        query((64'd1 << 5) | (64'd1 << 6));
        write_row(6'd20, 64'd1 << 12);
        query((64'd1 << 12) | (64'd1 << 20));
        write_row(6'd30, 64'd1 << 31);
        write_row(6'd31, 64'd1 << 32);
        write_row(6'd32, (64'd1 << 33) | (64'd1 << 30));
        write_row(6'd33, 64'd1 << 63);
        query('1);
        query(64'h0000_0003_C000_0000);
        write_row(6'd63, 64'd1);
        query(64'h8000_0000_0000_0001);
        write_row(6'd63, '1);
        query('1);
        query(64'hAAAA_AAAA_AAAA_AAAA);

        while (sent < 180)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < 180; k++)
            begin
                random_item();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                gap($urandom_range(1, 8));
            if (sent >= 90 && !paused)
            begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (400) @(posedge clk);
        $display("summary: %0d row writes and %0d queries sent, %0d components checked",
                 writes_sent, queries_sent, checked);
        if (mismatches == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d components outstanding", pending);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
